/* src/aes_pkg.sv */
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int RK_AW      = 4;

    localparam logic [7:0] GF_REDUCE = 8'h1B;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic REG_KEY_UPPER = 1'b0;
    localparam logic REG_KEY_LOWER = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] block_upper;
        logic [63:0] block_lower;
    } t_in;

    typedef struct packed {
        logic [63:0] out_upper;
        logic [63:0] out_lower;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Byte x sits at bits [2047-8x -: 8].
    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] RSBOX_BITS = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_BITS[11'd2047 - {x, 3'b000} -: 8];
    endfunction

    function automatic logic [7:0] rsbox(input logic [7:0] x);
        return RSBOX_BITS[11'd2047 - {x, 3'b000} -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [RK_AW-1:0] j);
        logic [7:0] v;
        case (j)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* src/aes_keysched.sv */
module aes_keysched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [127:0]                i_key,
    input  logic [aes_pkg::RK_AW-1:0]   i_rd_addr,
    output logic [127:0]                o_rd_data,
    output logic                        o_busy
);
    import aes_pkg::*;

    logic [127:0]     rk_mem [0:NUM_ROUNDS];
    logic [127:0]     r_rd_data;
    logic [127:0]     r_kx;
    logic [127:0]     n_kx;
    logic [RK_AW-1:0] r_cnt;
    logic             r_busy;
    logic [31:0]      rot;
    logic [31:0]      t;

    always_comb begin
        rot = {r_kx[23:0], r_kx[31:24]};
        t = {sbox(rot[31:24]) ^ rcon(r_cnt + 4'd1), sbox(rot[23:16]),
             sbox(rot[15:8]), sbox(rot[7:0])};
        n_kx[127:96] = r_kx[127:96] ^ t;
        n_kx[95:64]  = r_kx[95:64]  ^ n_kx[127:96];
        n_kx[63:32]  = r_kx[63:32]  ^ n_kx[95:64];
        n_kx[31:0]   = r_kx[31:0]   ^ n_kx[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_kx   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_kx   <= i_key;
        end else if (r_busy) begin
            r_kx  <= n_kx;
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == RK_AW'(NUM_ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && !i_start && r_busy) begin
            rk_mem[r_cnt] <= r_kx;
        end
        r_rd_data <= rk_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* src/aes_round.sv */
module aes_round (
    input  logic [127:0] i_blk,
    input  logic [127:0] i_key,
    input  logic         i_dec,
    input  logic         i_first,
    input  logic         i_last,
    output logic [127:0] o_blk
);
    import aes_pkg::*;

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] v;
        v = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    v[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = s[127 - 8 * (c * 4 + r) -: 8];
                end else begin
                    v[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * (((c + r) & 3) * 4 + r) -: 8];
                end
            end
        end
        return v;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] v;
        for (int i = 0; i < 16; i++) begin
            v[8 * i +: 8] = inv ? rsbox(s[8 * i +: 8]) : sbox(s[8 * i +: 8]);
        end
        return v;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m0 [4];
        logic [31:0] v;
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8 * k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            if (inv) begin
                m0[k] = x8[k] ^ x4[k] ^ x2[k];
                m1[k] = x8[k] ^ x2[k] ^ a[k];
                m2[k] = x8[k] ^ x4[k] ^ a[k];
                m3[k] = x8[k] ^ a[k];
            end else begin
                m0[k] = x2[k];
                m1[k] = x2[k] ^ a[k];
                m2[k] = a[k];
                m3[k] = a[k];
            end
        end
        for (int r = 0; r < 4; r++) begin
            v[31 - 8 * r -: 8] = m0[r] ^ m1[(r + 1) & 3] ^ m2[(r + 2) & 3] ^ m3[(r + 3) & 3];
        end
        return v;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] v;
        for (int c = 0; c < 4; c++) begin
            v[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
        end
        return v;
    endfunction

    logic [127:0] enc_sr;
    logic [127:0] enc_mc;
    logic [127:0] dec_ark;

    always_comb begin
        enc_sr  = shift_rows(sub_bytes(i_blk, 1'b0), 1'b0);
        enc_mc  = i_last ? enc_sr : mix_columns(enc_sr, 1'b0);
        dec_ark = sub_bytes(shift_rows(i_blk, 1'b1), 1'b1) ^ i_key;
        if (i_first) begin
            o_blk = i_blk ^ i_key;
        end else if (i_dec == CMD_DEC) begin
            o_blk = i_last ? dec_ark : mix_columns(dec_ark, 1'b1);
        end else begin
            o_blk = enc_mc ^ i_key;
        end
    end

endmodule

/* src/aes128_block_cipher_top.sv */
// AES-128 ECB engine: each input transaction carries a 128-bit block and a command
// (encrypt or decrypt) and yields one 128-bit result. A single round unit is iterated
// against round keys read from an 11-entry round-key memory; the initial key addition
// and the ten rounds are applied in turn and the last round's result is loaded into the
// output register. The next input is taken in the cycle after the last round at the
// earliest, so one block is in flight at a time. A stalled output holds its result;
// a block finishing during the stall waits in the round register and delays the next
// acceptance until the stall clears. After reset and after every key register write
// the key is re-expanded into that memory, one round key per cycle; input is stalled.
module aes128_block_cipher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aes_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aes_pkg::t_out       o_out_data
);
    import aes_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [RK_AW-1:0] r_step;
    logic [127:0]     r_blk;
    logic             r_dec;
    logic [63:0]      r_key_upper;
    logic [63:0]      r_key_lower;
    logic             r_out_valid;
    t_out             r_out_data;

    logic             ks_start;
    logic [127:0]     ks_key;
    logic [RK_AW-1:0] rd_addr;
    logic [127:0]     rk;
    logic             ks_busy;
    logic [127:0]     round_out;
    logic             last_step;
    logic             out_free;
    logic             in_accept;
    logic             load_out;

    assign ks_start  = i_cfg_we;
    assign ks_key    = (i_cfg_idx == REG_KEY_UPPER) ? {i_cfg_data, r_key_lower}
                                                    : {r_key_upper, i_cfg_data};
    assign last_step = (r_step == RK_AW'(NUM_ROUNDS));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    aes_keysched u_keysched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ks_start),
        .i_key     (ks_key),
        .i_rd_addr (rd_addr),
        .o_rd_data (rk),
        .o_busy    (ks_busy)
    );

    aes_round u_round (
        .i_blk   (r_blk),
        .i_key   (rk),
        .i_dec   (r_dec),
        .i_first (r_step == '0),
        .i_last  (last_step),
        .o_blk   (round_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_step) begin
                    n_state = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        rd_addr    = '0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = ks_busy || i_cfg_we;
                rd_addr    = (i_in_data.command == CMD_DEC) ? RK_AW'(NUM_ROUNDS) : '0;
            end
            ST_ROUND: begin
                rd_addr  = (r_dec == CMD_DEC) ? RK_AW'(NUM_ROUNDS - 1) - r_step
                                              : r_step + 4'd1;
                load_out = last_step && out_free;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEY_UPPER) begin
                    r_key_upper <= i_cfg_data;
                end else begin
                    r_key_lower <= i_cfg_data;
                end
            end
            if (in_accept) begin
                r_step <= '0;
            end else if (r_state == ST_ROUND && !last_step) begin
                r_step <= r_step + 4'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_blk <= {i_in_data.block_upper, i_in_data.block_lower};
            r_dec <= i_in_data.command;
        end else if (r_state == ST_ROUND) begin
            r_blk <= round_out;
        end
        if (load_out) begin
            r_out_data <= (r_state == ST_ROUND) ? t_out'(round_out) : t_out'(r_blk);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/aes_chk.sv */
module aes_chk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_in_valid,
    input  logic          o_in_stall,
    input  logic          o_out_valid,
    input  logic          i_out_stall,
    input  aes_pkg::t_out o_out_data
);
    import aes_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one item in flight at a time
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a transaction is in flight");

    // key expansion blocks input
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input open during key expansion");

    // a result is presented once the round sequence that follows acceptance is done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##12 o_out_valid)
        else $error("result missing after round sequence");

endmodule

bind aes128_block_cipher_top aes_chk u_chk (.*);
